>>> hdl/srtt_pkg.sv
`timescale 1ns / 1ps

package srtt_pkg;

  localparam int MAX_RADIX_DEF = 16;
  localparam int MAX_DIGITS    = 32;
  localparam int DIGIT_W       = 4;
  localparam int SYM_W         = 8;
  localparam int RADIX_W       = 5;
  localparam int CNT_W         = 6;
  localparam int VALUE_W       = 32;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0]    RESET_RADIX        = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RESET_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] RESET_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_MUL,
    ST_DIV_BACK,
    ST_DIV_FIX,
    ST_SIGN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // floor(2^32 / r): estimate of the quotient, low by at most one
  function automatic logic [VALUE_W-1:0] recip_of(input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] m;
    unique case (r)
      5'd2:    m = 32'h8000_0000;
      5'd3:    m = 32'h5555_5555;
      5'd4:    m = 32'h4000_0000;
      5'd5:    m = 32'h3333_3333;
      5'd6:    m = 32'h2AAA_AAAA;
      5'd7:    m = 32'h2492_4924;
      5'd8:    m = 32'h2000_0000;
      5'd9:    m = 32'h1C71_C71C;
      5'd10:   m = 32'h1999_9999;
      5'd11:   m = 32'h1745_D174;
      5'd12:   m = 32'h1555_5555;
      5'd13:   m = 32'h13B1_3B13;
      5'd14:   m = 32'h1249_2492;
      5'd15:   m = 32'h1111_1111;
      5'd16:   m = 32'h1000_0000;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/signed_radix_to_text.sv
`timescale 1ns / 1ps

// Signed integer to text in a configurable radix. Each accepted value beat
// produces one output beat per character, most significant digit first, with
// a leading '-' for negative values; last marks the final character. The
// radix (2 to MAX_RADIX) and the digit alphabet live in configuration
// registers and must only be written while the block is idle. Before each
// conversion the alphabet is checked; a radix out of range, a '+' or '-'
// among the used symbols, or two equal used symbols drops the item with no
// output at all. The block handles one item at a time and stalls its input
// while busy. Each item goes through accept and alphabet check, then for each
// digit a reciprocal estimate, a back multiply and a remainder correction on
// the one shared 32x32 multiplier, then the sign step (taken for every value,
// it loads the '-' of a negative one), then a read and a load per digit
// character through the registered-read digit RAM; an output stall holds the
// load steps and the sign step of a negative value.
module signed_radix_to_text #(
  parameter int MAX_RADIX = srtt_pkg::MAX_RADIX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // value channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [srtt_pkg::VALUE_W-1:0] value,
  // character channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [srtt_pkg::SYM_W-1:0]       symbol,
  output logic                             last,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srtt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srtt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import srtt_pkg::*;

  localparam int RAM_AW    = $clog2(MAX_DIGITS);
  localparam int SYM_IDX_W = $clog2(MAX_RADIX);
  localparam logic [2*CFG_DATA_W-1:0] RESET_SYMBOLS = {RESET_SYMBOLS_HIGH, RESET_SYMBOLS_LOW};

  // Configuration registers
  logic [RADIX_W-1:0] radix;
  logic [SYM_W-1:0]   sym [MAX_RADIX];

  // Sequencer and datapath
  state_t               state, state_next;
  logic [VALUE_W-1:0]   mag;
  logic                 negative;
  logic [RADIX_W-1:0]   rad;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quo;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     cnt_m1;

  logic                 alpha_ok;
  logic [VALUE_W-1:0]   op_a, op_b;
  logic [2*VALUE_W-1:0] mult_res;
  logic [VALUE_W:0]     rem_full;
  logic [CNT_W-1:0]     rem, rem_sub;
  logic                 fix_hi;
  logic [DIGIT_W-1:0]   digit;
  logic [VALUE_W-1:0]   quo_fixed;
  logic                 div_done;
  logic                 out_free;
  logic                 out_load;
  logic                 ram_we;
  logic [DIGIT_W-1:0]   ram_rdata;
  logic [SYM_W-1:0]     sym_rd;

  // Writes are always taken; the user must issue them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RESET_RADIX;
      for (int k = 0; k < MAX_RADIX; k++) begin
        sym[k] <= RESET_SYMBOLS[SYM_W*k +: SYM_W];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX: begin
          radix <= cfg_data[RADIX_W-1:0];
        end
        CFG_SYM_LOW: begin
          for (int k = 0; k < MAX_RADIX; k++) begin
            if (k < 8) sym[k] <= cfg_data[SYM_W*(k%8) +: SYM_W];
          end
        end
        CFG_SYM_HIGH: begin
          for (int k = 0; k < MAX_RADIX; k++) begin
            if (k >= 8) sym[k] <= cfg_data[SYM_W*(k%8) +: SYM_W];
          end
        end
        default: ;
      endcase
    end
  end

  // Alphabet check: every used symbol against sign characters and against
  // every later used symbol, all compares side by side
  always_comb begin
    alpha_ok = (radix >= RADIX_W'(2)) && (32'(radix) <= MAX_RADIX);
    for (int a = 0; a < MAX_RADIX; a++) begin
      if (32'(radix) > a) begin
        if (sym[a] == CHAR_PLUS || sym[a] == CHAR_MINUS) alpha_ok = 1'b0;
        for (int b = a + 1; b < MAX_RADIX; b++) begin
          if (32'(radix) > b && sym[a] == sym[b]) alpha_ok = 1'b0;
        end
      end
    end
  end

  // Shared multiplier: reciprocal estimate first, then the back multiply
  assign op_a     = (state == ST_DIV_MUL) ? mag : prod[2*VALUE_W-1:VALUE_W];
  assign op_b     = (state == ST_DIV_MUL) ? recip_of(rad) : {{(VALUE_W-RADIX_W){1'b0}}, rad};
  assign mult_res = op_a * op_b;

  // Remainder correction: the estimate is low by at most one, so one
  // compare and subtract settles both digit and quotient
  assign rem_full  = {1'b0, mag} - {1'b0, prod[VALUE_W-1:0]};
  assign rem       = rem_full[CNT_W-1:0];
  assign fix_hi    = rem >= {1'b0, rad};
  assign rem_sub   = rem - {1'b0, rad};
  assign digit     = fix_hi ? rem_sub[DIGIT_W-1:0] : rem[DIGIT_W-1:0];
  assign quo_fixed = quo + {{(VALUE_W-1){1'b0}}, fix_hi};
  assign div_done  = (quo_fixed == '0) || (count == CNT_W'(MAX_DIGITS - 1));

  assign cnt_m1   = count - CNT_W'(1);
  assign out_free = !out_valid || !out_stall;
  assign sym_rd   = sym[ram_rdata[SYM_IDX_W-1:0]];

  srtt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[RAM_AW-1:0]),
    .wdata (digit),
    .raddr (cnt_m1[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHECK;
      ST_CHECK:    state_next = alpha_ok ? ST_DIV_MUL : ST_IDLE;
      ST_DIV_MUL:  state_next = ST_DIV_BACK;
      ST_DIV_BACK: state_next = ST_DIV_FIX;
      ST_DIV_FIX:  state_next = div_done ? ST_SIGN : ST_DIV_MUL;
      ST_SIGN:     if (!negative || out_free) state_next = ST_EMIT_RD;
      ST_EMIT_RD:  state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) state_next = (count == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:    in_stall = 1'b0;
      ST_DIV_FIX: ram_we   = 1'b1;
      ST_SIGN:    out_load = negative && out_free;
      ST_EMIT_LD: out_load = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        count <= '0;
      end else if (state == ST_DIV_FIX) begin
        count <= count + CNT_W'(1);
      end else if (state == ST_EMIT_LD && out_free) begin
        count <= cnt_m1;
      end
      // hold the beat until taken, refill in the same cycle it drains
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      negative <= value[VALUE_W-1];
      mag      <= value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value)) : $unsigned(value);
    end
    if (state == ST_CHECK) begin
      rad <= radix;
    end
    if (state == ST_DIV_MUL || state == ST_DIV_BACK) begin
      prod <= mult_res;
    end
    if (state == ST_DIV_BACK) begin
      quo <= prod[2*VALUE_W-1:VALUE_W];
    end
    if (state == ST_DIV_FIX) begin
      mag <= quo_fixed;
    end
    if (out_load) begin
      symbol <= (state == ST_SIGN) ? CHAR_MINUS : sym_rd;
      last   <= (state == ST_EMIT_LD) && (count == CNT_W'(1));
    end
  end

  // The reciprocal estimate must leave a remainder below twice the radix
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_FIX |-> rem_full < {{(VALUE_W-RADIX_W){1'b0}}, rad, 1'b0})
    else $error("remainder correction out of range");

  a_div_radix: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_MUL |-> rad >= RADIX_W'(2) && 32'(rad) <= MAX_RADIX)
    else $error("division started with a rejected radix");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD || state == ST_EMIT_LD) |-> count != '0)
    else $error("emit with empty digit buffer");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LD && out_free && count == CNT_W'(1))
      |=> state == ST_IDLE && out_valid && last)
    else $error("final character not flagged");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("digit count overflow");

endmodule

>>> hdl/srtt_ram.sv
`timescale 1ns / 1ps

module srtt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> verif/tb_signed_radix_to_text.sv
`timescale 1ns / 1ps

// One character beat as it leaves the block.
typedef struct packed {
  logic [srtt_pkg::SYM_W-1:0] sym;
  logic                       last;
} text_char_t;

// Mirrors the configuration registers and predicts the character stream.
class radix_text_board;
  logic [srtt_pkg::RADIX_W-1:0]    radix;
  logic [srtt_pkg::CFG_DATA_W-1:0] sym_lo;
  logic [srtt_pkg::CFG_DATA_W-1:0] sym_hi;
  text_char_t                      pending_chars[$];
  int                              errors;

  function new();
    radix  = srtt_pkg::RESET_RADIX;
    sym_lo = srtt_pkg::RESET_SYMBOLS_LOW;
    sym_hi = srtt_pkg::RESET_SYMBOLS_HIGH;
    errors = 0;
  endfunction

  function void write_reg(logic [srtt_pkg::CFG_IDX_W-1:0] idx,
                          logic [srtt_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      srtt_pkg::CFG_RADIX:    radix  = data[srtt_pkg::RADIX_W-1:0];
      srtt_pkg::CFG_SYM_LOW:  sym_lo = data;
      srtt_pkg::CFG_SYM_HIGH: sym_hi = data;
      default: ;
    endcase
  endfunction

  function logic [srtt_pkg::SYM_W-1:0] symbol_of(int k);
    if (k < 8) return sym_lo[8*k +: 8];
    return sym_hi[8*(k-8) +: 8];
  endfunction

  function bit alphabet_usable();
    logic [srtt_pkg::SYM_W-1:0] s;
    if (radix < 2 || radix > srtt_pkg::MAX_RADIX_DEF) return 1'b0;
    for (int a = 0; a < radix; a++) begin
      s = symbol_of(a);
      if (s == srtt_pkg::CHAR_PLUS || s == srtt_pkg::CHAR_MINUS) return 1'b0;
      for (int b = a + 1; b < radix; b++)
        if (symbol_of(b) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_value(logic signed [srtt_pkg::VALUE_W-1:0] v);
    logic [srtt_pkg::VALUE_W-1:0] mag;
    logic [srtt_pkg::VALUE_W-1:0] base;
    int                           digits[$];
    text_char_t                   c;
    if (!alphabet_usable()) return;
    base = {27'd0, radix};
    mag  = v[srtt_pkg::VALUE_W-1] ? (32'd0 - v) : v;
    do begin
      digits.push_back(int'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (v[srtt_pkg::VALUE_W-1]) begin
      c.sym  = srtt_pkg::CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      c.sym  = symbol_of(digits[k]);
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  function void check_char(logic [srtt_pkg::SYM_W-1:0] sym, logic last);
    text_char_t want;
    if (pending_chars.size() == 0) begin
      errors++;
      $display("%0t: unexpected character, expected none, actual %h last %b",
               $time, sym, last);
      return;
    end
    want = pending_chars.pop_front();
    if (want.sym !== sym) begin
      errors++;
      $display("%0t: symbol mismatch, expected %h, actual %h", $time, want.sym, sym);
    end
    if (want.last !== last) begin
      errors++;
      $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
    end
  endfunction

  function int pending();
    return pending_chars.size();
  endfunction
endclass

module tb_signed_radix_to_text;
  import srtt_pkg::*;

  localparam int                   SETTLE_CYCLES = 200;   // longer than the slowest unstalled item
  localparam int                   IDLE_LIMIT    = 3000;
  localparam int                   RANDOM_ITEMS  = 130;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;  // no register behind it

  typedef logic signed [VALUE_W-1:0] value_q_t[$];

  typedef enum int {ALPHA_GOOD, ALPHA_BAD_RADIX, ALPHA_SIGN, ALPHA_REPEAT} alpha_kind_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic signed [VALUE_W-1:0]   value     = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [SYM_W-1:0]            symbol;
  logic                        last;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data  = '0;

  radix_text_board sb = new();

  int          burst_left = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  signed_radix_to_text DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Check every character beat that the receiver takes. Signals read here
  // still hold their pre-edge values, so the handshake is seen as the block
  // saw it.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(symbol, last);
  end

  // Receiver stall pattern: switch to a randomly chosen mode whenever the current one runs out, so
  // that stalls land on the sign, the digits and the last beat alike, with
  // clean stretches in between.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= (stall_tick % 3 != 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d characters outstanding", $time, sb.pending());
      $display("tb_signed_radix_to_text: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold one register write until the block takes it; leave valid up so a
  // following write goes out back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Push one value beat, then decide whether the current burst ends here.
  // Valid is dropped only in the step where no new beat follows.
  task automatic push_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_value(v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Wait for every predicted character, then let a rejected item or any
  // trailing work finish before the registers may change.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program the alphabet (unless told to keep the current one), send the
  // values and drain.
  task automatic run_phase(input bit program_regs, input logic [CFG_DATA_W-1:0] rdata,
                           input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                           input value_q_t vals);
    if (program_regs) begin
      write_reg(CFG_SYM_LOW, lo);
      write_reg(CFG_SYM_HIGH, hi);
      write_reg(CFG_RADIX, rdata);
      cfg_valid <= 1'b0;
    end
    foreach (vals[i]) push_value(vals[i]);
    in_valid <= 1'b0;
    drain();
  endtask

  // Mostly ordinary numbers, with small ones and the extremes mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 200)) - 100;
      4:       return $signed({{16{1'b0}}, 16'($urandom)}) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Build a random alphabet of a randomly chosen kind and run a phase on it. Symbols
  // past the radix are left fully random: '+', '-' and repeats there must not
  // reject anything.
  task automatic random_phase(output int sent);
    alpha_kind_t           kind;
    logic [SYM_W-1:0]      syms[16];
    bit [255:0]            taken;
    logic [CFG_DATA_W-1:0] lo, hi, rdata;
    value_q_t              vals;
    int                    r, a, b, n;
    kind  = ($urandom_range(0, 4) != 0) ? ALPHA_GOOD : alpha_kind_t'($urandom_range(1, 3));
    r     = $urandom_range(2, 16);
    taken = '0;
    for (a = 0; a < 16; a++) begin
      if (a < r) begin
        do syms[a] = SYM_W'($urandom_range(0, 255));
        while (taken[syms[a]] || syms[a] == CHAR_PLUS || syms[a] == CHAR_MINUS);
        taken[syms[a]] = 1'b1;
      end else begin
        syms[a] = SYM_W'($urandom_range(0, 255));
      end
    end
    case (kind)
      ALPHA_BAD_RADIX: r = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
      ALPHA_SIGN: syms[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      ALPHA_REPEAT: begin
        a = $urandom_range(0, r - 2);
        b = $urandom_range(a + 1, r - 1);
        syms[b] = syms[a];
      end
      default: ;
    endcase
    for (a = 0; a < 8; a++) begin
      lo[8*a +: 8] = syms[a];
      hi[8*a +: 8] = syms[a + 8];
    end
    // Upper bits of the radix write are junk; only the low five count.
    rdata = {$urandom, $urandom};
    rdata[RADIX_W-1:0] = r[RADIX_W-1:0];
    // Now and then poke the unused index; nothing may change.
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    n = (kind == ALPHA_GOOD) ? $urandom_range(8, 20) : $urandom_range(2, 4);
    for (a = 0; a < n; a++) vals.push_back(pick_value());
    run_phase(1'b1, rdata, lo, hi, vals);
    sent = (kind == ALPHA_GOOD) ? n : 0;
  endtask

  initial begin
    int sent, total;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset alphabet, decimal: zero, unit values and both ends of the range.
    run_phase(1'b0, '0, '0, '0, '{32'sd0, 32'sd1, -32'sd1, 32'sd7, -32'sd10,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1000000000, -32'sd999999999});
    // Binary with a zero byte and 0xFF as digits; '+' and '-' sit above the
    // radix and must be ignored. The most negative value gives 33 beats.
    run_phase(1'b1, 64'd2, 64'h2B2D_2B2D_2B2D_FF00, 64'h2D2D_2B2B_0000_FFFF,
              '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1});
    // Hex, radix written with all upper bits set.
    run_phase(1'b1, 64'hFFFF_FFFF_FFFF_FFF0, RESET_SYMBOLS_LOW, 64'h6665_6463_6261_3938,
              '{-32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1234_5678});
    // Radix out of range: each item must vanish.
    run_phase(1'b1, 64'd0, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH, '{-32'sd12345});
    run_phase(1'b1, 64'd1, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH, '{32'sd5});
    run_phase(1'b1, 64'd17, RESET_SYMBOLS_LOW, 64'h6665_6463_6261_3938, '{32'sd99});
    run_phase(1'b1, 64'd31, RESET_SYMBOLS_LOW, 64'h6665_6463_6261_3938, '{-32'sd1});
    // Sign symbol among the used digits, then a repeated digit.
    run_phase(1'b1, 64'd10, 64'h3736_3534_2B32_3130, RESET_SYMBOLS_HIGH, '{32'sd42});
    run_phase(1'b1, 64'd10, RESET_SYMBOLS_LOW, 64'h0000_0000_0000_2D38, '{-32'sd42});
    run_phase(1'b1, 64'd10, 64'h3036_3534_3332_3130, RESET_SYMBOLS_HIGH, '{32'sd7});
    // Radix 12 on the reset alphabet: digits 10 and 11 are both zero bytes.
    run_phase(1'b1, 64'd12, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH, '{32'sd1234});

    // Random alphabets and values; rejected phases do not count toward the total.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      random_phase(sent);
      total += sent;
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_signed_radix_to_text: done, clean");
    end else begin
      $display("tb_signed_radix_to_text: done, errors");
    end
    $finish;
  end

endmodule
